// ----- sv/header_length_footer_deframer_assert.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef HEADER_LENGTH_FOOTER_DEFRAMER_ASSERT_SVH
`define HEADER_LENGTH_FOOTER_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked outside reset.
`define HLFD_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Checked on every edge, reset included.
`define HLFD_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define HLFD_ASSERT(name, clk, rst, prop)
`define HLFD_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ----- sv/hlfd_pkg.sv -----
package hlfd_pkg;

  localparam logic [7:0] START_BYTE = 8'h24;
  localparam logic [7:0] END_BYTE   = 8'h25;

  localparam logic OP_RECV = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [2:0] ST_HUNT      = 3'd0;
  localparam logic [2:0] ST_RECV      = 3'd1;
  localparam logic [2:0] ST_FRAME_OK  = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_BAD_END   = 3'd4;
  localparam logic [2:0] ST_READ_OK   = 3'd5;
  localparam logic [2:0] ST_READ_OOR  = 3'd6;

  localparam logic [9:0]  MAX_LEN_RESET = 10'd1021;
  localparam logic [15:0] MIN_LEN       = 16'd3;

  typedef logic [9:0] cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
    logic [9:0] read_index;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] frame_type;
    logic [9:0] frame_length;
    logic [7:0] read_data;
  } rsp_t;

  // Result of one item before the store read data joins it.
  typedef struct packed {
    logic [2:0] status;
    logic [7:0] frame_type;
    logic [9:0] frame_length;
  } step_t;

endpackage

// ----- sv/hlfd_stream_if.sv -----
interface hlfd_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/hlfd_ram.sv -----
module hlfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/hlfd_core.sv -----
module hlfd_core #(
  parameter int STORE_BYTES = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  hlfd_pkg::req_t item,
  input  hlfd_pkg::cfg_t max_len,
  output hlfd_pkg::step_t step,
  output logic [7:0]     rd_data
);

  localparam int AW = $clog2(STORE_BYTES);
  localparam int PW = 11;
  localparam logic [15:0] CAP = 16'(STORE_BYTES - 3);
  localparam logic [31:0] STORE_LIMIT = 32'(STORE_BYTES);

  localparam logic [1:0] PH_HUNT   = 2'd0;
  localparam logic [1:0] PH_LEN_LO = 2'd1;
  localparam logic [1:0] PH_LEN_HI = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  logic [1:0]    phase, phase_next;
  logic [7:0]    len_lo, len_lo_next;
  logic [9:0]    len, len_next;
  logic [PW-1:0] pos, pos_next;
  logic [7:0]    cur_type, cur_type_next;
  logic [7:0]    good_type, good_type_next;
  logic [9:0]    good_len, good_len_next;

  logic [2:0]    status;
  logic [15:0]   len16;
  logic          len_bad;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] frame_end;
  logic          wr;
  logic [AW-1:0] waddr;
  logic          in_range;

  always_comb begin
    phase_next     = phase;
    len_lo_next    = len_lo;
    len_next       = len;
    pos_next       = pos;
    cur_type_next  = cur_type;
    good_type_next = good_type;
    good_len_next  = good_len;
    status         = hlfd_pkg::ST_HUNT;
    wr             = 1'b0;
    waddr          = AW'(pos);

    len16     = {item.rx_byte, len_lo};
    len_bad   = len16[15] || (len16 < hlfd_pkg::MIN_LEN) ||
                (len16 > {6'd0, max_len}) || (len16 > CAP);
    pos_inc   = pos + 1'b1;
    frame_end = {1'b0, len} + PW'(3);
    in_range  = {22'd0, item.read_index} < STORE_LIMIT;

    if (item.opcode == hlfd_pkg::OP_READ) begin
      status = in_range ? hlfd_pkg::ST_READ_OK : hlfd_pkg::ST_READ_OOR;
    end else begin
      unique case (phase)
        PH_HUNT: begin
          if (item.rx_byte == hlfd_pkg::START_BYTE) begin
            wr         = 1'b1;
            waddr      = '0;
            pos_next   = PW'(1);
            phase_next = PH_LEN_LO;
            status     = hlfd_pkg::ST_RECV;
          end
        end
        PH_LEN_LO: begin
          wr          = 1'b1;
          waddr       = AW'(1);
          len_lo_next = item.rx_byte;
          pos_next    = PW'(2);
          phase_next  = PH_LEN_HI;
          status      = hlfd_pkg::ST_RECV;
        end
        PH_LEN_HI: begin
          wr       = 1'b1;
          waddr    = AW'(2);
          pos_next = PW'(3);
          if (len_bad) begin
            phase_next = PH_HUNT;
            status     = hlfd_pkg::ST_BAD_LEN;
          end else begin
            len_next   = len16[9:0];
            phase_next = PH_BODY;
            status     = hlfd_pkg::ST_RECV;
          end
        end
        PH_BODY: begin
          wr       = 1'b1;
          pos_next = pos_inc;
          // The type byte sits at offset 5; every accepted length reaches it.
          if (pos == PW'(5)) begin
            cur_type_next = item.rx_byte;
          end
          if (pos_inc < frame_end) begin
            status = hlfd_pkg::ST_RECV;
          end else begin
            phase_next = PH_HUNT;
            if (item.rx_byte != hlfd_pkg::END_BYTE) begin
              status = hlfd_pkg::ST_BAD_END;
            end else begin
              good_type_next = (pos == PW'(5)) ? item.rx_byte : cur_type;
              good_len_next  = len;
              status         = hlfd_pkg::ST_FRAME_OK;
            end
          end
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HUNT;
      len_lo    <= '0;
      len       <= '0;
      pos       <= '0;
      good_type <= '0;
      good_len  <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      len_lo    <= len_lo_next;
      len       <= len_next;
      pos       <= pos_next;
      good_type <= good_type_next;
      good_len  <= good_len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_type <= cur_type_next;
    end
  end

  assign step.status       = status;
  assign step.frame_type   = good_type_next;
  assign step.frame_length = good_len_next;

  hlfd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (accept && wr),
    .waddr (waddr),
    .wdata (item.rx_byte),
    .re    (accept && (item.opcode == hlfd_pkg::OP_READ) && in_range),
    .raddr (AW'(item.read_index)),
    .rdata (rd_data)
  );

endmodule

// ----- sv/header_length_footer_deframer.sv -----
// Frame extractor for a byte stream of the form: start byte, 16-bit
// little-endian length L, then L bytes ending in the end byte.
// req carries one item per transfer: a received byte (opcode receive) or a
// read of a stored frame byte by offset (opcode read). rsp returns exactly
// one result per item: status, type and length of the last good frame, and
// the read byte. cfg writes the largest accepted frame length.
// Throughput is one item per cycle while rsp is not stalled. A result reaches
// rsp through the middle stage: the transfer edge updates the parser, loads
// the middle stage and issues the frame store access, and the output register
// is loaded from it once free. The frame store is a single write, single read
// RAM with a registered read port. When rsp is stalled, one more item is taken
// into the middle stage; req then drops ready until the output register is
// free, so nothing is lost. Reset empties both stages, sets the maximum length
// to 1021, clears the good frame record and starts hunting for a start byte.
// req and cfg hold ready low while rst is high. The store itself is not
// cleared; an offset is only meaningful once a frame has written it.
module header_length_footer_deframer #(
  parameter int STORE_BYTES = 1024
) (
  input logic          clk,
  input logic          rst,
  hlfd_stream_if.sink   req,
  hlfd_stream_if.source rsp,
  hlfd_stream_if.sink   cfg
);

`include "header_length_footer_deframer_assert.svh"

  hlfd_pkg::cfg_t  max_len;
  hlfd_pkg::step_t step;
  hlfd_pkg::step_t s1;
  hlfd_pkg::rsp_t  out;
  logic            s1_valid;
  logic            out_valid;
  logic            out_free;
  logic            accept;
  logic [7:0]      rd_data;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= hlfd_pkg::MAX_LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_len <= cfg.data;
    end
  end

  assign out_free  = !out_valid || rsp.ready;
  // The middle stage holds the store read data, so it only takes a new item
  // when its current one can move on.
  assign req.ready = !rst && (!s1_valid || out_free);
  assign accept    = req.valid && req.ready;

  hlfd_core #(
    .STORE_BYTES (STORE_BYTES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (req.data),
    .max_len (max_len),
    .step    (step),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= step;
    end
    if (out_free && s1_valid) begin
      out.status       <= s1.status;
      out.frame_type   <= s1.frame_type;
      out.frame_length <= s1.frame_length;
      out.read_data    <= (s1.status == hlfd_pkg::ST_READ_OK) ? rd_data : 8'd0;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out;

  `HLFD_ASSERT(a_s1_hold, clk, rst, s1_valid && !out_free |=> s1_valid && $stable(s1))
  `HLFD_ASSERT(a_read_zero, clk, rst, out_valid && out.status != hlfd_pkg::ST_READ_OK |-> out.read_data == 8'd0)
  `HLFD_ASSERT(a_ok_len, clk, rst, out_valid && out.status == hlfd_pkg::ST_FRAME_OK |-> out.frame_length >= 10'd3)
  `HLFD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !s1_valid && !out_valid)

endmodule

// ----- tb/sv/tb_header_length_footer_deframer.sv -----
`timescale 1ns / 100ps

module tb_header_length_footer_deframer;

  localparam int STORE_BYTES    = 1024;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 62;
  localparam int REPORT_LIMIT   = 10;

  typedef enum logic [1:0] {SEEK_START, GET_LEN_LO, GET_LEN_HI, GET_BODY} parse_ph_t;
  typedef enum int {ALWAYS_READY, RANDOM_STALL, PATTERN_STALL} stall_t;

  typedef struct {
    hlfd_pkg::req_t item;
    bit             typed;
    hlfd_pkg::rsp_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  hlfd_stream_if #(.data_t(hlfd_pkg::req_t)) req_if ();
  hlfd_stream_if #(.data_t(hlfd_pkg::rsp_t)) rsp_if ();
  hlfd_stream_if #(.data_t(hlfd_pkg::cfg_t)) cfg_if ();

  header_length_footer_deframer #(.STORE_BYTES(STORE_BYTES)) uut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  // Mirror of the deframer state.
  parse_ph_t      parse_ph = SEEK_START;
  logic [15:0]    len_acc = '0;
  int             byte_pos = 0;
  logic [7:0]     store_m [STORE_BYTES];
  bit             written [STORE_BYTES];
  logic [7:0]     last_type = '0;
  logic [9:0]     last_len = '0;
  hlfd_pkg::cfg_t max_len = hlfd_pkg::MAX_LEN_RESET;

  hlfd_pkg::rsp_t pending_results [$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   burst_left = 0;
  int   stim_count = 0;
  bit   hold_ask = 1'b0;
  int   idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int len_limit();
    return (int'(max_len) < STORE_BYTES - 3) ? int'(max_len) : STORE_BYTES - 3;
  endfunction

  function automatic void keep_byte(int at, logic [7:0] b);
    if (at < STORE_BYTES) begin
      store_m[at] = b;
      written[at] = 1'b1;
    end
  endfunction

  function automatic hlfd_pkg::rsp_t deframe_predict(hlfd_pkg::req_t it);
    hlfd_pkg::rsp_t r;
    r = '0;
    if (it.opcode == hlfd_pkg::OP_READ) begin
      if (int'(it.read_index) < STORE_BYTES) begin
        r.status = hlfd_pkg::ST_READ_OK;
        r.read_data = store_m[it.read_index];
      end else begin
        r.status = hlfd_pkg::ST_READ_OOR;
      end
    end else begin
      case (parse_ph)
        SEEK_START: begin
          if (it.rx_byte == hlfd_pkg::START_BYTE) begin
            keep_byte(0, it.rx_byte);
            byte_pos = 1;
            len_acc = '0;
            parse_ph = GET_LEN_LO;
            r.status = hlfd_pkg::ST_RECV;
          end else begin
            r.status = hlfd_pkg::ST_HUNT;
          end
        end
        GET_LEN_LO: begin
          keep_byte(1, it.rx_byte);
          len_acc = {8'h00, it.rx_byte};
          byte_pos = 2;
          parse_ph = GET_LEN_HI;
          r.status = hlfd_pkg::ST_RECV;
        end
        GET_LEN_HI: begin
          keep_byte(2, it.rx_byte);
          len_acc = {it.rx_byte, len_acc[7:0]};
          byte_pos = 3;
          if (len_acc[15] || len_acc < hlfd_pkg::MIN_LEN ||
              int'(len_acc) > len_limit()) begin
            parse_ph = SEEK_START;
            r.status = hlfd_pkg::ST_BAD_LEN;
          end else begin
            parse_ph = GET_BODY;
            r.status = hlfd_pkg::ST_RECV;
          end
        end
        default: begin
          keep_byte(byte_pos, it.rx_byte);
          byte_pos++;
          if (byte_pos < int'(len_acc) + 3) begin
            r.status = hlfd_pkg::ST_RECV;
          end else begin
            parse_ph = SEEK_START;
            if (it.rx_byte != hlfd_pkg::END_BYTE) begin
              r.status = hlfd_pkg::ST_BAD_END;
            end else begin
              last_type = store_m[5];
              last_len = len_acc[9:0];
              r.status = hlfd_pkg::ST_FRAME_OK;
            end
          end
        end
      endcase
    end
    r.frame_type = last_type;
    r.frame_length = last_len;
    return r;
  endfunction

  function automatic dir_row_t drow(logic op, logic [7:0] b, logic [9:0] idx, bit typed,
                                    logic [2:0] st, logic [7:0] ty, logic [9:0] ln,
                                    logic [7:0] rd);
    dir_row_t row;
    row.item.opcode = op;
    row.item.rx_byte = b;
    row.item.read_index = idx;
    row.typed = typed;
    row.want.status = st;
    row.want.frame_type = ty;
    row.want.frame_length = ln;
    row.want.read_data = rd;
    return row;
  endfunction

  // Mix of random lengths: mostly short good ones, with every kind of rejected length.
  function automatic int unsigned pick_len();
    int lim;
    int sel;
    lim = len_limit();
    sel = $urandom_range(0, 19);
    if (sel == 0) return $urandom_range(16'h8000, 16'hFFFF);
    if (sel == 1) return $urandom_range(0, 2);
    if (sel == 2) return lim + 1 + $urandom_range(0, 3);
    if (sel == 3) return $urandom_range(lim + 1, 16'h7FFF);
    if (lim < 3) return $urandom_range(0, 30);
    if (sel == 4 && lim <= 64) return lim;
    return $urandom_range(3, (lim < 24) ? lim : 24);
  endfunction

  task automatic send_item(hlfd_pkg::req_t it, bit typed, hlfd_pkg::rsp_t want);
    int gap;
    hlfd_pkg::rsp_t r;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.data <= it;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    r = deframe_predict(it);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic send_recv(logic [7:0] b);
    hlfd_pkg::req_t it;
    it.opcode = hlfd_pkg::OP_RECV;
    it.rx_byte = b;
    it.read_index = 10'($urandom);
    send_item(it, 1'b0, '0);
  endtask

  // Only offsets that some frame has already written are read back.
  task automatic send_read();
    hlfd_pkg::req_t it;
    it.opcode = hlfd_pkg::OP_READ;
    it.rx_byte = 8'($urandom);
    it.read_index = 10'($urandom_range(0, STORE_BYTES - 1));
    if (!written[it.read_index]) it.read_index = '0;
    stim_count++;
    send_item(it, 1'b0, '0);
  endtask

  // A high length byte of all ones is always rejected, so the parser gets back
  // to hunting without a long body.
  task automatic flush_parser();
    while (parse_ph != SEEK_START)
      send_recv((parse_ph == GET_LEN_HI) ? 8'hFF : 8'($urandom));
  endtask

  task automatic send_frame(int unsigned l, bit good_end, int cut);
    logic [15:0] l16;
    logic [7:0]  b;
    int          total;
    bit          cut_short;
    l16 = l[15:0];
    total = (!l16[15] && l16 >= hlfd_pkg::MIN_LEN && int'(l16) <= len_limit()) ?
            int'(l16) + 3 : 3;
    cut_short = (cut >= 0 && cut < total);
    if (cut_short) total = cut;
    for (int n = 0; n < total; n++) begin
      if (n == 0) begin
        b = hlfd_pkg::START_BYTE;
      end else if (n == 1) begin
        b = l16[7:0];
      end else if (n == 2) begin
        b = l16[15:8];
      end else if (n < total - 1 || cut_short) begin
        b = 8'($urandom);
      end else if (good_end) begin
        b = hlfd_pkg::END_BYTE;
      end else begin
        do b = 8'($urandom); while (b == hlfd_pkg::END_BYTE);
      end
      stim_count++;
      send_recv(b);
      if (n >= 3 && n + 1 < total && $urandom_range(0, 15) == 0) send_read();
    end
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_max_len(hlfd_pkg::cfg_t v);
    drain();
    repeat (4) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    max_len = v;
  endtask

  initial begin
    stall_t mode;
    int     hold_left;
    int     cyc;
    mode = ALWAYS_READY;
    hold_left = 0;
    cyc = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 128 == 0) mode = stall_t'($urandom_range(0, 2));
      if (hold_ask) begin
        hold_ask = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        case (mode)
          ALWAYS_READY: rsp_if.ready <= 1'b1;
          RANDOM_STALL: rsp_if.ready <= ($urandom_range(0, 2) != 0);
          default:      rsp_if.ready <= (cyc % 5 != 0) && ((cyc / 16) % 4 != 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    hlfd_pkg::rsp_t got;
    hlfd_pkg::rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d unexpected: status %0d type %h length %0d data %h",
                   results_seen, got.status, got.frame_type, got.frame_length, got.read_data);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.frame_type !== want.frame_type ||
            got.frame_length !== want.frame_length || got.read_data !== want.read_data) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display({"result %0d: expected status %0d type %h length %0d data %h, ",
                      "got status %0d type %h length %0d data %h"},
                     results_seen, want.status, want.frame_type, want.frame_length,
                     want.read_data, got.status, got.frame_type, got.frame_length,
                     got.read_data);
        end
      end
    end
  end

  // Any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t       dir_rows [$];
    hlfd_pkg::cfg_t phase_cfg [8];
    int             target;
    int             sel;
    rst <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data <= '0;

    // Rejected lengths (too short, sign bit, above the maximum), one good frame,
    // one frame with a bad end byte, then reads of what they left behind.
    dir_rows = '{
      drow(hlfd_pkg::OP_RECV, 8'h00, 10'd0,   1, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'hFF, 10'h3FF, 1, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h24, 10'd0,   1, hlfd_pkg::ST_RECV,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h02, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h00, 10'd0,   1, hlfd_pkg::ST_BAD_LEN,  8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h24, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h00, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h80, 10'd0,   1, hlfd_pkg::ST_BAD_LEN,  8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h24, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'hFE, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h03, 10'd0,   1, hlfd_pkg::ST_BAD_LEN,  8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h24, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h04, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h00, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h11, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h22, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'hA5, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h25, 10'd0,   1, hlfd_pkg::ST_FRAME_OK, 8'hA5, 10'd4, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h24, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h03, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h00, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h01, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h02, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00),
      drow(hlfd_pkg::OP_RECV, 8'h7E, 10'd0,   1, hlfd_pkg::ST_BAD_END,  8'hA5, 10'd4, 8'h00),
      drow(hlfd_pkg::OP_READ, 8'h00, 10'd5,   1, hlfd_pkg::ST_READ_OK,  8'hA5, 10'd4, 8'h7E),
      drow(hlfd_pkg::OP_READ, 8'hFF, 10'd0,   0, hlfd_pkg::ST_HUNT,     8'h00, 10'd0, 8'h00)
    };

    // Above the largest length that fits the store, below the minimum, at the minimum and at full size.
    phase_cfg = '{10'd1023, 10'd0, 10'd2, 10'd3, 10'd1021,
                  10'($urandom_range(3, 1021)), 10'($urandom_range(3, 64)), 10'd48};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    foreach (phase_cfg[p]) begin
      write_max_len(phase_cfg[p]);
      if (p == 4 || p == 6) hold_ask = 1'b1;
      if (p == 0) send_frame(1022, 1'b1, -1);
      target = stim_count + PHASE_ITEMS;
      while (stim_count < target) begin
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
          flush_parser();
          send_frame(pick_len(), $urandom_range(0, 7) != 0, -1);
        end else if (sel < 80) begin
          send_read();
        end else if (sel < 90) begin
          repeat ($urandom_range(1, 4)) send_recv(8'($urandom));
        end else begin
          flush_parser();
          send_frame(pick_len(), 1'b1, $urandom_range(1, 6));
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
